FILE: rtl/core/rfd_pkg.sv
// Shared types and constants for the range frame deframer.
`timescale 1ns / 1ps
package rfd_pkg;

    localparam int RFD_LENGTH_LIMIT = 64;

    localparam logic [7:0] START_BYTE = 8'h62;
    localparam logic [7:0] ID_DOWN    = 8'h00;
    localparam logic [7:0] ID_UP      = 8'h01;

    localparam int RANGE_W = 15;

    localparam logic [RANGE_W-1:0] LO_LIMIT_RESET = 15'd10;
    localparam logic [RANGE_W-1:0] HI_LIMIT_RESET = 15'd4000;

    localparam logic CFG_LO_LIMIT = 1'b0;
    localparam logic CFG_HI_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        PH_LEN     = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_SUM     = 2'd2
    } t_phase;

    typedef struct packed {
        logic               sensor_select;
        logic [RANGE_W-1:0] range_cm;
        logic               range_valid;
    } t_result;

endpackage

FILE: rtl/core/rfd_in_reg.sv
// Input byte register of the range frame deframer.
`timescale 1ns / 1ps
module rfd_in_reg
    import rfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data,
    input  logic       i_advance,
    output logic       o_valid,
    output logic [7:0] o_data
);

    logic       r_valid;
    logic [7:0] r_data;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= i_data;
        end
    end

endmodule

FILE: rtl/core/rfd_parser.sv
// Frame parser state machine, payload store and range check.
`timescale 1ns / 1ps
module rfd_parser
    import rfd_pkg::*;
#(
    parameter int LENGTH_LIMIT = RFD_LENGTH_LIMIT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [RANGE_W-1:0] i_cfg_wdata,
    input  logic               i_valid,
    input  logic [7:0]         i_byte,
    input  logic               i_can_load,
    output logic               o_advance,
    output logic               o_result_valid,
    output t_result            o_result
);

    localparam int LEN_W = $clog2(LENGTH_LIMIT);
    localparam logic [8:0] LIMIT9 = 9'(LENGTH_LIMIT);

    logic [RANGE_W-1:0] r_lo_limit;
    logic [RANGE_W-1:0] r_hi_limit;

    logic             r_in_frame;
    t_phase           r_phase;
    logic [LEN_W-1:0] r_byte_count;
    logic [LEN_W-1:0] r_payload_len;
    logic [7:0]       r_sum;
    logic [7:0]       r_payload [3];

    logic             n_in_frame;
    t_phase           n_phase;
    logic [LEN_W-1:0] n_byte_count;
    logic [LEN_W-1:0] n_payload_len;
    logic [7:0]       n_sum;

    logic             store_we;
    logic             gen_result;
    logic             take;
    logic [15:0]      raw;
    logic             in_limits;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo_limit <= LO_LIMIT_RESET;
            r_hi_limit <= HI_LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LO_LIMIT: r_lo_limit <= i_cfg_wdata;
                CFG_HI_LIMIT: r_hi_limit <= i_cfg_wdata;
                default:      r_lo_limit <= r_lo_limit;
            endcase
        end
    end

    assign gen_result = r_in_frame && (r_phase == PH_SUM) && (r_sum == i_byte)
                     && (r_payload_len == LEN_W'(3))
                     && ((r_payload[0] == ID_DOWN) || (r_payload[0] == ID_UP));

    assign take      = i_valid && (!gen_result || i_can_load);
    assign o_advance = take;

    assign raw       = {r_payload[1], r_payload[2]};
    assign in_limits = !raw[15] && (raw[RANGE_W-1:0] >= r_lo_limit)
                     && (raw[RANGE_W-1:0] < r_hi_limit);

    assign o_result_valid         = take && gen_result;
    assign o_result.sensor_select = r_payload[0][0];
    assign o_result.range_cm      = in_limits ? raw[RANGE_W-1:0] : '0;
    assign o_result.range_valid   = in_limits;

    always_comb begin
        n_in_frame    = r_in_frame;
        n_phase       = r_phase;
        n_byte_count  = r_byte_count;
        n_payload_len = r_payload_len;
        n_sum         = r_sum;
        store_we      = 1'b0;
        if (!r_in_frame) begin
            if (i_byte == START_BYTE) begin
                n_in_frame   = 1'b1;
                n_phase      = PH_LEN;
                n_byte_count = '0;
                n_sum        = i_byte;
            end
        end else begin
            case (r_phase)
                PH_LEN: begin
                    if ({1'b0, i_byte} < LIMIT9) begin
                        n_payload_len = i_byte[LEN_W-1:0];
                        n_sum         = r_sum + i_byte;
                        n_phase       = (i_byte == 8'd0) ? PH_SUM : PH_PAYLOAD;
                    end else begin
                        n_in_frame = 1'b0;
                        n_phase    = PH_LEN;
                    end
                end
                PH_PAYLOAD: begin
                    store_we     = (r_byte_count < LEN_W'(3));
                    n_byte_count = r_byte_count + LEN_W'(1);
                    n_sum        = r_sum + i_byte;
                    if (n_byte_count >= r_payload_len) begin
                        n_phase = PH_SUM;
                    end
                end
                PH_SUM: begin
                    n_in_frame = 1'b0;
                    n_phase    = PH_LEN;
                end
                default: begin
                    n_in_frame = 1'b0;
                    n_phase    = PH_LEN;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame    <= 1'b0;
            r_phase       <= PH_LEN;
            r_byte_count  <= '0;
            r_payload_len <= '0;
            r_sum         <= '0;
        end else if (take) begin
            r_in_frame    <= n_in_frame;
            r_phase       <= n_phase;
            r_byte_count  <= n_byte_count;
            r_payload_len <= n_payload_len;
            r_sum         <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && store_we) begin
            r_payload[r_byte_count[1:0]] <= i_byte;
        end
    end

endmodule

FILE: rtl/core/rfd_out_reg.sv
// Result register of the range frame deframer.
`timescale 1ns / 1ps
module rfd_out_reg
    import rfd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    output logic    o_can_load,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

FILE: rtl/core/range_frame_deframer_top.sv
// Top level of the range frame deframer.
// A result is registered at the output when the parser takes its checksum byte.
// Throughput: one byte per cycle; the input register stalls only while a
// finished result waits in the output register and the next byte completes a frame.
// Reset: synchronous active low; clears frame state and limits to 10 and 4000 cm.
`timescale 1ns / 1ps
module range_frame_deframer_top
    import rfd_pkg::*;
#(
    parameter int LENGTH_LIMIT = RFD_LENGTH_LIMIT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [RANGE_W-1:0] i_cfg_wdata,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // [7:0] rx_byte
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [15:0]        m_axis_tdata,   // [14:0] range_cm, [15] range_valid
    output logic               m_axis_tuser    // [0] sensor_select
);

    logic       in_valid;
    logic [7:0] in_byte;
    logic       advance;
    logic       can_load;
    logic       res_valid;
    t_result    res;
    t_result    out_res;

    rfd_in_reg u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_data    (s_axis_tdata),
        .i_advance (advance),
        .o_valid   (in_valid),
        .o_data    (in_byte)
    );

    rfd_parser #(
        .LENGTH_LIMIT (LENGTH_LIMIT)
    ) u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (in_valid),
        .i_byte         (in_byte),
        .i_can_load     (can_load),
        .o_advance      (advance),
        .o_result_valid (res_valid),
        .o_result       (res)
    );

    rfd_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (res_valid),
        .i_result   (res),
        .o_can_load (can_load),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_result   (out_res)
    );

    assign m_axis_tdata = {out_res.range_valid, out_res.range_cm};
    assign m_axis_tuser = out_res.sensor_select;

endmodule

FILE: rtl/core/rfd_checker.sv
// Port-level assertions for the range frame deframer, bound to the top level.
`timescale 1ns / 1ps
module rfd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        i_s_tready,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] i_m_tdata,
    input logic        i_m_tuser
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("result shown right after reset");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_m_tvalid) |-> $past(i_s_tvalid && i_s_tready, 2))
        else $error("result without a byte accepted two cycles earlier");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tdata[15]) |-> (i_m_tdata[14:0] == 15'd0))
        else $error("out-of-limit range not forced to zero");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tready) |=>
            (i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser)))
        else $error("stalled result changed");

endmodule

bind range_frame_deframer_top rfd_checker u_rfd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tuser  (m_axis_tuser)
);

FILE: tb/range_frame_deframer_top_tb.sv
// Self-checking testbench for the range frame deframer with a byte-level scoreboard.
`timescale 1ns / 1ps
module range_frame_deframer_top_tb;
    import rfd_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 8;

    typedef logic [7:0] t_byte_q[$];

    class t_range_scoreboard;
        logic [RANGE_W-1:0] lo_limit;
        logic [RANGE_W-1:0] hi_limit;
        logic               in_frame;
        t_phase             phase;
        logic [7:0]         byte_count;
        logic [5:0]         payload_len;
        logic [7:0]         running_sum;
        logic [7:0]         payload [3];
        t_result            expected_q[$];
        int                 errors;

        function new();
            lo_limit    = LO_LIMIT_RESET;
            hi_limit    = HI_LIMIT_RESET;
            in_frame    = 1'b0;
            phase       = PH_LEN;
            byte_count  = '0;
            payload_len = '0;
            running_sum = '0;
            errors      = 0;
        endfunction

        function void set_limits(logic [RANGE_W-1:0] lo, logic [RANGE_W-1:0] hi);
            lo_limit = lo;
            hi_limit = hi;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_byte(logic [7:0] b);
            t_result r;
            int      signed_range;
            bit      in_limits;
            if (!in_frame) begin
                if (b == START_BYTE) begin
                    in_frame    = 1'b1;
                    phase       = PH_LEN;
                    byte_count  = '0;
                    running_sum = b;
                end
                return;
            end
            case (phase)
                PH_LEN: begin
                    if (int'(b) < RFD_LENGTH_LIMIT) begin
                        payload_len = b[5:0];
                        running_sum = running_sum + b;
                        phase = (b == 8'd0) ? PH_SUM : PH_PAYLOAD;
                    end else begin
                        in_frame = 1'b0;
                        phase    = PH_LEN;
                    end
                end
                PH_PAYLOAD: begin
                    if (byte_count < 8'd3) payload[byte_count[1:0]] = b;
                    byte_count  = byte_count + 8'd1;
                    running_sum = running_sum + b;
                    if (byte_count >= {2'b00, payload_len}) phase = PH_SUM;
                end
                PH_SUM: begin
                    in_frame = 1'b0;
                    phase    = PH_LEN;
                    if (running_sum == b && payload_len == 6'd3 &&
                        (payload[0] == ID_DOWN || payload[0] == ID_UP)) begin
                        signed_range    = $signed({payload[1], payload[2]});
                        in_limits       = signed_range >= int'(lo_limit) &&
                                          signed_range < int'(hi_limit);
                        r.sensor_select = payload[0][0];
                        r.range_cm      = in_limits ? signed_range[RANGE_W-1:0] : '0;
                        r.range_valid   = in_limits;
                        expected_q.push_back(r);
                    end
                end
                default: begin
                    in_frame = 1'b0;
                    phase    = PH_LEN;
                end
            endcase
        endfunction

        function void check_result(t_result got);
            t_result exp;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result sel=%0d range=%0d valid=%0d", $time,
                         got.sensor_select, got.range_cm, got.range_valid);
                errors++;
                return;
            end
            exp = expected_q.pop_front();
            if (got.sensor_select !== exp.sensor_select) begin
                $display("%0t: sensor_select mismatch, expected %0d, actual %0d", $time,
                         exp.sensor_select, got.sensor_select);
                errors++;
            end
            if (got.range_cm !== exp.range_cm) begin
                $display("%0t: range_cm mismatch, expected %0d, actual %0d", $time,
                         exp.range_cm, got.range_cm);
                errors++;
            end
            if (got.range_valid !== exp.range_valid) begin
                $display("%0t: range_valid mismatch, expected %0d, actual %0d", $time,
                         exp.range_valid, got.range_valid);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_we      = 1'b0;
    logic               i_cfg_index   = CFG_LO_LIMIT;
    logic [RANGE_W-1:0] i_cfg_wdata   = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata  = '0;   // [7:0] rx_byte
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [15:0]        m_axis_tdata;         // [14:0] range_cm, [15] range_valid
    logic               m_axis_tuser;         // [0] sensor_select

    t_range_scoreboard sb;
    bit                idle_on     = 1'b1;
    int                bytes_sent  = 0;
    int                ready_hold  = 0;
    int                idle_cycles = 0;

    range_frame_deframer_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ready_hold    <= 0;
            m_axis_tready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold    <= ready_hold - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            ready_hold    <= $urandom_range(1, 18) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        if (s_axis_tvalid && s_axis_tready) sb.note_byte(s_axis_tdata);
        if (m_axis_tvalid && m_axis_tready) begin
            got.sensor_select = m_axis_tuser;
            got.range_cm      = m_axis_tdata[RANGE_W-1:0];
            got.range_valid   = m_axis_tdata[15];
            sb.check_result(got);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        bytes_sent++;
    endtask

    // Append the wrapping byte sum when asked, optionally corrupt it, then send.
    task automatic send_bytes(input t_byte_q q, input bit add_sum, input bit bad_sum);
        logic [7:0] sum;
        sum = '0;
        foreach (q[i]) sum = sum + q[i];
        if (bad_sum) sum = sum ^ (8'd1 << $urandom_range(0, 7));
        if (add_sum) q.push_back(sum);
        foreach (q[i]) send_byte(q[i]);
    endtask

    function automatic logic [15:0] pick_range();
        case ($urandom_range(0, 6))
            0: return 16'($urandom_range(0, 65535));
            1: return 16'(sb.lo_limit) + 16'($urandom_range(0, 2)) - 16'd1;
            2: return 16'(sb.hi_limit) + 16'($urandom_range(0, 2)) - 16'd1;
            3: return $urandom_range(0, 1) ? 16'h7FFF : 16'h0000;
            4: return $urandom_range(0, 1) ? 16'h8000 : 16'hFFFF;
            default: return 16'($urandom_range(sb.lo_limit, sb.hi_limit));
        endcase
    endfunction

    task automatic send_frame();
        t_byte_q     q;
        logic [7:0]  len;
        logic [15:0] rng;
        int          kind;
        int          cut;
        kind = $urandom_range(0, 99);
        q    = {};
        if (kind < 12) begin
            repeat ($urandom_range(1, 4)) q.push_back(8'($urandom_range(0, 255)));
            send_bytes(q, 1'b0, 1'b0);
        end else if (kind < 17) begin
            q = {START_BYTE, 8'($urandom_range(RFD_LENGTH_LIMIT, 255))};
            send_bytes(q, 1'b0, 1'b0);
        end else begin
            if (kind < 75) begin
                len = 8'd3;
                rng = pick_range();
                q   = {START_BYTE, len,
                       ($urandom_range(0, 9) == 0) ? 8'($urandom_range(2, 255))
                                                   : 8'($urandom_range(0, 1)),
                       rng[15:8], rng[7:0]};
            end else begin
                len = ($urandom_range(0, 7) == 0) ? 8'(RFD_LENGTH_LIMIT - 1)
                                                  : 8'($urandom_range(0, 8));
                q   = {START_BYTE, len};
                repeat (len) q.push_back(($urandom_range(0, 2) == 0) ?
                                         8'($urandom_range(0, 255)) :
                                         8'($urandom_range(0, 1)));
            end
            if ($urandom_range(0, 19) == 0) begin
                cut = $urandom_range(1, q.size() - 1);
                q   = q[0:cut-1];
                send_bytes(q, 1'b0, 1'b0);
            end else begin
                send_bytes(q, 1'b1, $urandom_range(0, 9) == 0);
            end
        end
    endtask

    task automatic send_random(input int count);
        int target;
        target = bytes_sent + count;
        while (bytes_sent < target) send_frame();
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limits(input logic [RANGE_W-1:0] lo, input logic [RANGE_W-1:0] hi);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_LO_LIMIT;
        i_cfg_wdata <= lo;
        @(posedge i_clk);
        i_cfg_index <= CFG_HI_LIMIT;
        i_cfg_wdata <= hi;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_limits(lo, hi);
    endtask

    initial begin
        int lo;
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_bytes({8'h00, 8'hFF}, 1'b0, 1'b0);
        send_bytes({START_BYTE, 8'd3, ID_DOWN, 8'h03, 8'hE8}, 1'b1, 1'b0);
        send_bytes({START_BYTE, 8'd3, ID_UP, 8'h80, 8'h00}, 1'b1, 1'b0);
        send_bytes({START_BYTE, 8'(RFD_LENGTH_LIMIT)}, 1'b0, 1'b0);
        send_bytes({START_BYTE, 8'd0}, 1'b1, 1'b0);
        send_bytes({START_BYTE, 8'd3, ID_UP, 8'h00, 8'h0A}, 1'b1, 1'b1);
        send_random(200);

        drain();
        write_limits(15'd0, 15'd32767);
        send_random(205);

        drain();
        write_limits(15'd32767, 15'd0);
        send_random(205);

        drain();
        lo = $urandom_range(0, 32767);
        write_limits(15'(lo), 15'(lo));
        send_random(205);

        drain();
        lo = $urandom_range(0, 2000);
        write_limits(15'(lo), 15'($urandom_range(lo + 1, 32767)));
        send_random(205);

        drain();
        write_limits(15'($urandom_range(0, 100)), 15'($urandom_range(20000, 32767)));
        idle_on <= 1'b0;
        send_random(205);

        drain();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
